/* sv/lspo_pkg.sv */
package lspo_pkg;

  // Command codes
  localparam logic [3:0] CMD_ADD        = 4'd0;
  localparam logic [3:0] CMD_REMOVE     = 4'd1;
  localparam logic [3:0] CMD_SELECT     = 4'd2;
  localparam logic [3:0] CMD_NEXT       = 4'd3;
  localparam logic [3:0] CMD_PREV       = 4'd4;
  localparam logic [3:0] CMD_PEEK_NEXT  = 4'd5;
  localparam logic [3:0] CMD_PEEK_PREV  = 4'd6;
  localparam logic [3:0] CMD_RESHUFFLE  = 4'd7;
  localparam logic [3:0] CMD_CLEAR      = 4'd8;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NONE      = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  // Register indexes
  localparam logic REG_LOOP_ENABLE = 1'b0;
  localparam logic REG_RNG_SEED    = 1'b1;

  localparam int ID_W    = 16;
  localparam int COUNT_W = 9;
  localparam int LCG_W   = 48;
  localparam int RND_W   = 31;
  localparam int AVOID_W = 4;

  localparam logic [LCG_W-1:0] LCG_MULT = 48'h0005_DEEC_E66D;
  localparam logic [LCG_W-1:0] LCG_INC  = 48'h0000_0000_000B;

endpackage

/* sv/lspo_ram.sv */
module lspo_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/lspo_rand.sv */
// nrand48 step by serial shift-and-add multiply, then bits 47..17 reduced
// modulo range by restoring division.
module lspo_rand import lspo_pkg::*; #(
  parameter int CW = 9
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             seed_load,
  input  logic [LCG_W-1:0] seed,
  input  logic             start,
  input  logic [CW-1:0]    range,
  output logic             done,
  output logic [CW-1:0]    value
);

  localparam logic [1:0] R_IDLE = 2'd0;
  localparam logic [1:0] R_MUL  = 2'd1;
  localparam logic [1:0] R_INC  = 2'd2;
  localparam logic [1:0] R_MOD  = 2'd3;

  logic [1:0]       state;
  logic [LCG_W-1:0] lcg;
  logic [LCG_W-1:0] acc;
  logic [LCG_W-1:0] mcand;
  logic [LCG_W-1:0] mplier;
  logic [5:0]       step;
  logic [CW-1:0]    rng;
  logic [CW-1:0]    rem;
  logic [RND_W-1:0] vbits;
  logic [LCG_W-1:0] lcg_next;
  logic [CW:0]      trial;

  assign lcg_next = acc + LCG_INC;
  assign trial    = {rem, vbits[RND_W-1]};
  assign value    = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= R_IDLE;
      lcg   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        R_IDLE: begin
          if (seed_load) begin
            lcg <= seed;
          end
          if (start) begin
            acc    <= '0;
            mcand  <= LCG_MULT;
            mplier <= lcg;
            rng    <= range;
            step   <= '0;
            state  <= R_MUL;
          end
        end
        R_MUL: begin
          acc    <= acc + (mplier[0] ? mcand : '0);
          mcand  <= {mcand[LCG_W-2:0], 1'b0};
          mplier <= {1'b0, mplier[LCG_W-1:1]};
          step   <= step + 6'd1;
          if (step == 6'(LCG_W - 1)) begin
            state <= R_INC;
          end
        end
        R_INC: begin
          lcg   <= lcg_next;
          vbits <= lcg_next[LCG_W-1:LCG_W-RND_W];
          rem   <= '0;
          step  <= '0;
          state <= R_MOD;
        end
        R_MOD: begin
          if (trial >= {1'b0, rng}) begin
            rem <= CW'(trial - {1'b0, rng});
          end else begin
            rem <= trial[CW-1:0];
          end
          vbits <= {vbits[RND_W-2:0], 1'b0};
          step  <= step + 6'd1;
          if (step == 6'(RND_W - 1)) begin
            done  <= 1'b1;
            state <= R_IDLE;
          end
        end
        default: state <= R_IDLE;
      endcase
    end
  end

endmodule

/* sv/lazy_shuffle_play_order_core.sv */
// Shuffled play order over a table of 16-bit item IDs, drawn lazily.
// Input channel (in_valid/in_ready): one command with item_id per
// transaction. Output channel (out_valid/out_ready): exactly one result
// transaction per command, in order.
// Config port: cfg_write with cfg_index 0 sets loop_enable, 1 loads the
// 48-bit seed into the generator. Write only while the block is idle.
// Each entry moved for add, remove and select takes one RAM read and one
// RAM write, the ID search reads and checks each entry that it scans, and
// each random draw is a serial LCG multiply, a modulo and a swap.
// One command is in flight at a time; the next is taken as soon as the
// result is parked in the output register, even if the receiver stalls.
// Reset clears all pointers and counts; the table needs no clearing since
// only entries below the count are ever used.
module lazy_shuffle_play_order_core import lspo_pkg::*; #(
  parameter int CAPACITY     = 256,
  parameter int AVOID_REPEAT = 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         command,
  input  logic [ID_W-1:0]    item_id,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [ID_W-1:0]    result_item,
  output logic [1:0]         status,
  output logic               has_next,
  output logic               has_prev,
  output logic [COUNT_W-1:0] item_count,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [LCG_W-1:0]   cfg_data
);

  localparam int CW = $clog2(CAPACITY + 1);  // counts and positions
  localparam int AW = $clog2(CAPACITY);      // RAM address

  // Sequencer states
  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_OUT     = 5'd1;
  localparam logic [4:0] S_SH_RD   = 5'd2;
  localparam logic [4:0] S_SH_WR   = 5'd3;
  localparam logic [4:0] S_ADD_WR  = 5'd4;
  localparam logic [4:0] S_FIND_RD = 5'd5;
  localparam logic [4:0] S_FIND_CK = 5'd6;
  localparam logic [4:0] S_REM_A   = 5'd7;
  localparam logic [4:0] S_REM_B   = 5'd8;
  localparam logic [4:0] S_REM_C   = 5'd9;
  localparam logic [4:0] S_REM_D   = 5'd10;
  localparam logic [4:0] S_REM_E   = 5'd11;
  localparam logic [4:0] S_SEL_A   = 5'd12;
  localparam logic [4:0] S_SEL_B   = 5'd13;
  localparam logic [4:0] S_SEL_C   = 5'd14;
  localparam logic [4:0] S_SEL_D   = 5'd15;
  localparam logic [4:0] S_SEL_E   = 5'd16;
  localparam logic [4:0] S_NX_A    = 5'd17;
  localparam logic [4:0] S_RS_LOOP = 5'd18;
  localparam logic [4:0] S_RS_DEC  = 5'd19;
  localparam logic [4:0] S_NX_B    = 5'd20;
  localparam logic [4:0] S_NX_C    = 5'd21;
  localparam logic [4:0] S_NX_D    = 5'd22;
  localparam logic [4:0] S_PV_A    = 5'd23;
  localparam logic [4:0] S_PV_B    = 5'd24;
  localparam logic [4:0] S_D_START = 5'd25;
  localparam logic [4:0] S_D_WAIT  = 5'd26;
  localparam logic [4:0] S_D_RD2   = 5'd27;
  localparam logic [4:0] S_D_WR1   = 5'd28;
  localparam logic [4:0] S_D_WR2   = 5'd29;

  logic [4:0]         state;
  logic               loop_enable;

  // Pointers: [0,drawn_end) drawn, [drawn_end,history_mark) undrawn,
  // [history_mark,used_count) history of the previous pass.
  logic [CW-1:0]      used_count;
  logic [CW-1:0]      drawn_end;
  logic [CW-1:0]      cursor;
  logic [CW-1:0]      history_mark;

  logic [3:0]         cmd_r;
  logic [ID_W-1:0]    id_r;
  logic [ID_W-1:0]    item_r;
  logic [1:0]         status_r;
  logic [CW-1:0]      idx;        // found position, moves during remove/select
  logic [CW-1:0]      f_idx;      // search cursor

  // Block-move subroutine: each entry is read then written, so a
  // write always lands before the next read issues (no forwarding needed).
  logic [CW-1:0]      sh_dst;
  logic [CW-1:0]      sh_src;
  logic [CW-1:0]      sh_cnt;
  logic               sh_up;
  logic [4:0]         sh_ret;

  // Draw subroutine: random pick from the undrawn zone, swapped to drawn_end
  logic [AVOID_W-1:0] dr_avoid;
  logic [4:0]         dr_ret;
  logic [CW-1:0]      dsel;
  logic [ID_W-1:0]    dt;
  logic [AVOID_W-1:0] avoid_cnt;

  // RAM ports
  logic               ram_we;
  logic [CW-1:0]      ram_waddr;
  logic [ID_W-1:0]    ram_wdata;
  logic [CW-1:0]      ram_raddr;
  logic [ID_W-1:0]    ram_rdata;

  // Random unit
  logic               rnd_start;
  logic [CW-1:0]      rnd_range;
  logic               rnd_done;
  logic [CW-1:0]      rnd_value;
  logic               seed_load;

  // Derived flags
  logic               has_next_c;
  logic               has_prev_c;
  logic [CW-1:0]      hist_dist;
  logic [CW-1:0]      prev_idx;
  logic [AVOID_W-1:0] avoid_init;
  logic [CW-1:0]      undrawn;
  logic [CW-1:0]      cur_inc;

  lspo_ram #(
    .WIDTH(ID_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr[AW-1:0]),
    .wdata(ram_wdata),
    .raddr(ram_raddr[AW-1:0]),
    .rdata(ram_rdata)
  );

  lspo_rand #(
    .CW(CW)
  ) u_rand (
    .clk      (clk),
    .rst      (rst),
    .seed_load(seed_load),
    .seed     (cfg_data),
    .start    (rnd_start),
    .range    (rnd_range),
    .done     (rnd_done),
    .value    (rnd_value)
  );

  assign seed_load = cfg_write && (cfg_index == REG_RNG_SEED);
  assign in_ready  = (state == S_IDLE);

  // In loop mode the previous item is missing only right after wrapping
  // into the history zone: (cursor - history_mark) mod used_count == 1.
  always_comb begin
    if (cursor >= history_mark) begin
      hist_dist = cursor - history_mark;
      if (hist_dist == used_count) begin
        hist_dist = '0;
      end
    end else begin
      hist_dist = cursor + used_count - history_mark;
    end
  end

  assign has_next_c = (used_count != '0) && (loop_enable || (cursor < used_count));
  assign has_prev_c = (used_count != '0) &&
                      (loop_enable ? (hist_dist != CW'(1)) : (cursor > CW'(1)));

  // (cursor - 2) mod used_count
  always_comb begin
    if (cursor >= CW'(2)) begin
      prev_idx = cursor - CW'(2);
    end else if (cursor == CW'(1)) begin
      prev_idx = used_count - CW'(1);
    end else if (used_count >= CW'(2)) begin
      prev_idx = used_count - CW'(2);
    end else begin
      prev_idx = '0;
    end
  end

  assign avoid_init = ((32'(used_count) - 32'd1) < 32'(AVOID_REPEAT)) ?
                      AVOID_W'(used_count - CW'(1)) : AVOID_W'(AVOID_REPEAT);

  assign undrawn = used_count - drawn_end;
  assign cur_inc = cursor + CW'(1);

  always_comb begin
    rnd_start = (state == S_D_START) && (drawn_end < used_count);
    if (32'(undrawn) > 32'(dr_avoid)) begin
      rnd_range = undrawn - CW'(dr_avoid);
    end else begin
      rnd_range = CW'(1);
    end
  end

  // RAM port steering
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;
    unique case (state)
      S_SH_RD:   ram_raddr = sh_src;
      S_SH_WR: begin
        ram_we    = 1'b1;
        ram_waddr = sh_dst;
        ram_wdata = ram_rdata;
      end
      S_ADD_WR: begin
        ram_we    = 1'b1;
        ram_waddr = history_mark;
        ram_wdata = id_r;
      end
      S_FIND_RD: ram_raddr = f_idx;
      S_REM_B:   ram_raddr = history_mark - CW'(1);
      S_REM_C, S_SEL_C: begin
        ram_we    = 1'b1;
        ram_waddr = idx;
        ram_wdata = ram_rdata;
      end
      S_SEL_B:   ram_raddr = drawn_end;
      S_SEL_D: begin
        ram_we    = 1'b1;
        ram_waddr = drawn_end;
        ram_wdata = id_r;
      end
      S_SEL_E: begin
        ram_we    = 1'b1;
        ram_waddr = drawn_end - CW'(1);
        ram_wdata = id_r;
      end
      S_NX_C:    ram_raddr = cursor;
      S_PV_A:    ram_raddr = prev_idx;
      S_D_WAIT:  ram_raddr = drawn_end;
      S_D_RD2:   ram_raddr = dsel;
      S_D_WR1: begin
        ram_we    = 1'b1;
        ram_waddr = drawn_end;
        ram_wdata = ram_rdata;
      end
      S_D_WR2: begin
        ram_we    = 1'b1;
        ram_waddr = dsel;
        ram_wdata = dt;
      end
      default: ram_raddr = '0;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      loop_enable  <= 1'b0;
      used_count   <= '0;
      drawn_end    <= '0;
      cursor       <= '0;
      history_mark <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_write && (cfg_index == REG_LOOP_ENABLE)) begin
        loop_enable <= cfg_data[0];
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r    <= command;
            id_r     <= item_id;
            item_r   <= '0;
            status_r <= ST_OK;
            state    <= S_OUT;
            unique case (command)
              CMD_ADD: begin
                if (used_count >= CW'(CAPACITY)) begin
                  status_r <= ST_FULL;
                end else begin
                  // open a slot at history_mark, moving the history up
                  sh_dst <= used_count;
                  sh_src <= used_count - CW'(1);
                  sh_cnt <= used_count - history_mark;
                  sh_up  <= 1'b0;
                  sh_ret <= S_ADD_WR;
                  state  <= S_SH_RD;
                end
              end
              CMD_REMOVE, CMD_SELECT: begin
                f_idx <= '0;
                state <= S_FIND_RD;
              end
              CMD_NEXT, CMD_PEEK_NEXT: state <= S_NX_A;
              CMD_PREV, CMD_PEEK_PREV: state <= S_PV_A;
              CMD_RESHUFFLE: begin
                drawn_end    <= '0;
                cursor       <= '0;
                history_mark <= used_count;
              end
              CMD_CLEAR: begin
                used_count   <= '0;
                drawn_end    <= '0;
                cursor       <= '0;
                history_mark <= '0;
              end
              default: state <= S_OUT;
            endcase
          end
        end

        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            result_item <= item_r;
            status      <= status_r;
            has_next    <= has_next_c;
            has_prev    <= has_prev_c;
            item_count  <= COUNT_W'(used_count);
            state       <= S_IDLE;
          end
        end

        S_SH_RD: begin
          if (sh_cnt == '0) begin
            state <= sh_ret;
          end else begin
            state <= S_SH_WR;
          end
        end
        S_SH_WR: begin
          sh_cnt <= sh_cnt - CW'(1);
          if (sh_up) begin
            sh_dst <= sh_dst + CW'(1);
            sh_src <= sh_src + CW'(1);
          end else begin
            sh_dst <= sh_dst - CW'(1);
            sh_src <= sh_src - CW'(1);
          end
          state <= S_SH_RD;
        end

        S_ADD_WR: begin
          if (cursor > history_mark) begin
            cursor <= cur_inc;
          end
          history_mark <= history_mark + CW'(1);
          used_count   <= used_count + CW'(1);
          state        <= S_OUT;
        end

        // Linear search, lowest position wins
        S_FIND_RD: begin
          if (f_idx >= used_count) begin
            status_r <= ST_NOT_FOUND;
            state    <= S_OUT;
          end else begin
            state <= S_FIND_CK;
          end
        end
        S_FIND_CK: begin
          if (ram_rdata == id_r) begin
            idx   <= f_idx;
            state <= (cmd_r == CMD_REMOVE) ? S_REM_A : S_SEL_A;
          end else begin
            f_idx <= f_idx + CW'(1);
            state <= S_FIND_RD;
          end
        end

        // Remove: close the gap in the drawn zone, pull the last undrawn
        // entry into the hole, then close the gap in the history.
        S_REM_A: begin
          if (idx < cursor) begin
            cursor <= cursor - CW'(1);
          end
          if (idx < drawn_end) begin
            sh_dst    <= idx;
            sh_src    <= idx + CW'(1);
            sh_cnt    <= drawn_end - idx - CW'(1);
            sh_up     <= 1'b1;
            sh_ret    <= S_REM_B;
            drawn_end <= drawn_end - CW'(1);
            idx       <= drawn_end - CW'(1);
            state     <= S_SH_RD;
          end else begin
            state <= S_REM_B;
          end
        end
        S_REM_B: begin
          state <= (idx < history_mark) ? S_REM_C : S_REM_D;
        end
        S_REM_C: begin
          idx          <= history_mark - CW'(1);
          history_mark <= history_mark - CW'(1);
          state        <= S_REM_D;
        end
        S_REM_D: begin
          sh_dst <= idx;
          sh_src <= idx + CW'(1);
          sh_cnt <= used_count - idx - CW'(1);
          sh_up  <= 1'b1;
          sh_ret <= S_REM_E;
          state  <= S_SH_RD;
        end
        S_REM_E: begin
          used_count <= used_count - CW'(1);
          state      <= S_OUT;
        end

        // Select: move the item to the end of the drawn zone, cursor after it
        S_SEL_A: begin
          if ((history_mark != '0) && (idx >= history_mark)) begin
            sh_dst       <= idx;
            sh_src       <= idx - CW'(1);
            sh_cnt       <= idx - history_mark;
            sh_up        <= 1'b0;
            sh_ret       <= S_SEL_B;
            idx          <= history_mark;
            history_mark <= ((history_mark + CW'(1)) == used_count) ?
                            '0 : history_mark + CW'(1);
            state        <= S_SH_RD;
          end else begin
            state <= S_SEL_B;
          end
        end
        S_SEL_B: begin
          if (idx >= drawn_end) begin
            state <= S_SEL_C;
          end else begin
            sh_dst <= idx;
            sh_src <= idx + CW'(1);
            sh_cnt <= drawn_end - idx - CW'(1);
            sh_up  <= 1'b1;
            sh_ret <= S_SEL_E;
            state  <= S_SH_RD;
          end
        end
        S_SEL_C: state <= S_SEL_D;
        S_SEL_D: begin
          drawn_end <= drawn_end + CW'(1);
          cursor    <= drawn_end + CW'(1);
          state     <= S_OUT;
        end
        S_SEL_E: begin
          cursor <= drawn_end;
          state  <= S_OUT;
        end

        // Next / peek_next
        S_NX_A: begin
          if (!has_next_c) begin
            status_r <= ST_NONE;
            state    <= S_OUT;
          end else if ((cursor == used_count) && (cursor == history_mark)) begin
            // loop wrap: reshuffle, keeping the last items out of the first draws
            drawn_end    <= '0;
            cursor       <= '0;
            history_mark <= '0;
            avoid_cnt    <= avoid_init;
            state        <= S_RS_LOOP;
          end else begin
            state <= S_NX_B;
          end
        end
        S_RS_LOOP: begin
          if (avoid_cnt == '0) begin
            state <= S_NX_B;
          end else begin
            dr_avoid <= avoid_cnt;
            dr_ret   <= S_RS_DEC;
            state    <= S_D_START;
          end
        end
        S_RS_DEC: begin
          avoid_cnt <= avoid_cnt - AVOID_W'(1);
          state     <= S_RS_LOOP;
        end
        S_NX_B: begin
          if (cursor == drawn_end) begin
            if (drawn_end >= used_count) begin
              status_r <= ST_NONE;
              state    <= S_OUT;
            end else begin
              dr_avoid <= '0;
              dr_ret   <= S_NX_C;
              state    <= S_D_START;
            end
          end else begin
            state <= S_NX_C;
          end
        end
        S_NX_C: begin
          if (cursor >= used_count) begin
            status_r <= ST_NONE;
            state    <= S_OUT;
          end else begin
            state <= S_NX_D;
          end
        end
        S_NX_D: begin
          item_r <= ram_rdata;
          if (cmd_r == CMD_NEXT) begin
            cursor <= ((cur_inc == used_count) && (cur_inc != drawn_end)) ?
                      '0 : cur_inc;
          end
          state <= S_OUT;
        end

        // Prev / peek_prev
        S_PV_A: begin
          if (!has_prev_c) begin
            status_r <= ST_NONE;
            state    <= S_OUT;
          end else begin
            state <= S_PV_B;
          end
        end
        S_PV_B: begin
          item_r <= ram_rdata;
          if (cmd_r == CMD_PREV) begin
            cursor <= (cursor != '0) ? cursor - CW'(1) : used_count - CW'(1);
          end
          state <= S_OUT;
        end

        // Draw: swap a random undrawn entry to drawn_end
        S_D_START: begin
          state <= (drawn_end < used_count) ? S_D_WAIT : dr_ret;
        end
        S_D_WAIT: begin
          if (rnd_done) begin
            dsel  <= drawn_end + rnd_value;
            state <= S_D_RD2;
          end
        end
        S_D_RD2: begin
          dt    <= ram_rdata;
          state <= S_D_WR1;
        end
        S_D_WR1: state <= S_D_WR2;
        S_D_WR2: begin
          if (drawn_end == history_mark) begin
            history_mark <= history_mark + CW'(1);
          end
          drawn_end <= drawn_end + CW'(1);
          state     <= dr_ret;
        end

        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_zone_bounds: assert property (@(posedge clk) disable iff (rst)
    (drawn_end <= used_count) && (history_mark <= used_count) && (cursor <= used_count))
    else $error("play order pointer beyond item count");

  a_capacity: assert property (@(posedge clk) disable iff (rst)
    used_count <= CW'(CAPACITY))
    else $error("item count above capacity");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("new command taken while one is in progress");
`endif

endmodule
